@@ hw/rtl/ple_pkg.sv @@
// Package for the positional list engine: command and result structs,
// command kind and status codes, and the default list depth.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int PLE_DEPTH_DEFAULT = 32;

  // Command kinds carried in the kind field of an input transfer.
  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_INS_AT    = 3'd2;
  localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
  localparam logic [2:0] KIND_DEL_AT    = 3'd5;
  localparam logic [2:0] KIND_READ_OUT  = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [5:0]         length;
    logic               final_res;
  } ple_out_t;

endpackage

@@ hw/rtl/positional_list_engine.sv @@
// Positional list engine: an ordered list of signed 32-bit values in one memory.
// Insert moves each element from the target up one slot, then writes the value;
// delete moves each element above the target down one slot; a rejected or
// unused command gives a status result; read-out emits each element in turn. One
// command at a time; the input stalls until the last result is registered.
// Reset (rst_n low, synchronous) empties the list and drops any result.
`timescale 1ns / 1ps

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = PLE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ple_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ple_out_t out_data
);

  // AW indexes the memory; CW holds a count from 0 to DEPTH. XW is wide
  // enough to compare a 6-bit position against occupancy plus one.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW + 1 : 7;

  // The sequencer walks one element per iteration through the memory.
  // Each move is a read state followed by a write state, since the read
  // data is registered.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_REQ,
    S_RD_OUT,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  ple_in_t          cmd_r, cmd_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  ple_out_t         out_data_r, out_data_nxt;

  // Memory port signals.
  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;
  logic             we;
  logic             re;
  logic [AW-1:0]    wa;
  logic [AW-1:0]    ra;
  logic [31:0]      wd;

  logic             out_free;
  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    occ_x;
  logic [AW-1:0]    ins_idx;
  logic [AW-1:0]    del_idx;
  logic             rd_last;

  // The output register takes a new result when it is empty or its
  // current result is being transferred this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_x   = XW'(cmd_r.position);
  assign occ_x   = XW'(occ_r);
  assign rd_last = ((CW'(ptr_r) + CW'(1)) == occ_r);

  always_comb begin
    case (cmd_r.kind)
      KIND_INS_FRONT: ins_idx = '0;
      KIND_INS_BACK:  ins_idx = occ_r[AW-1:0];
      default:        ins_idx = AW'(cmd_r.position - 6'd1);
    endcase
    case (cmd_r.kind)
      KIND_DEL_FRONT: del_idx = '0;
      KIND_DEL_BACK:  del_idx = AW'(occ_r - CW'(1));
      default:        del_idx = AW'(cmd_r.position - 6'd1);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    occ_nxt       = occ_r;
    ptr_nxt       = ptr_r;
    tgt_nxt       = tgt_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    re            = 1'b0;
    wa            = ptr_r;
    ra            = ptr_r;
    wd            = rd_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        st_nxt = ST_OK;
        case (cmd_r.kind)
          KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
            if (occ_r == CW'(DEPTH)) begin
              st_nxt    = ST_FULL;
              state_nxt = S_EMIT;
            end else if (cmd_r.kind == KIND_INS_AT &&
                         (pos_x == '0 || pos_x > occ_x + XW'(1))) begin
              st_nxt    = ST_BADPOS;
              state_nxt = S_EMIT;
            end else begin
              // Move elements up one slot, from the back down to the target.
              tgt_nxt   = ins_idx;
              ptr_nxt   = occ_r[AW-1:0];
              state_nxt = (occ_r[AW-1:0] == ins_idx) ? S_PUT : S_SHIFT_RD;
            end
          end
          KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT: begin
            if ((cmd_r.kind != KIND_DEL_AT) && occ_r == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else if (cmd_r.kind == KIND_DEL_AT &&
                         (pos_x == '0 || pos_x > occ_x)) begin
              st_nxt    = ST_BADPOS;
              state_nxt = S_EMIT;
            end else begin
              // The count drops now; the loop closes the gap up to it.
              ptr_nxt   = del_idx;
              occ_nxt   = occ_r - CW'(1);
              state_nxt = ((CW'(del_idx) + CW'(1)) < occ_r) ? S_DEL_RD : S_EMIT;
            end
          end
          KIND_READ_OUT: begin
            if (occ_r == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_RD_REQ;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      S_SHIFT_RD: begin
        re        = 1'b1;
        ra        = ptr_r - AW'(1);
        state_nxt = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        we        = 1'b1;
        wa        = ptr_r;
        ptr_nxt   = ptr_r - AW'(1);
        state_nxt = ((ptr_r - AW'(1)) == tgt_r) ? S_PUT : S_SHIFT_RD;
      end

      S_PUT: begin
        we        = 1'b1;
        wa        = tgt_r;
        wd        = cmd_r.value;
        occ_nxt   = occ_r + CW'(1);
        state_nxt = S_EMIT;
      end

      S_DEL_RD: begin
        re        = 1'b1;
        ra        = ptr_r + AW'(1);
        state_nxt = S_DEL_WR;
      end

      S_DEL_WR: begin
        // The count is already the new one, so a slot below it still needs
        // the element above it.
        we        = 1'b1;
        wa        = ptr_r;
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = ((CW'(ptr_r) + CW'(1)) < occ_r) ? S_DEL_RD : S_EMIT;
      end

      S_RD_REQ: begin
        re        = 1'b1;
        ra        = ptr_r;
        state_nxt = S_RD_OUT;
      end

      S_RD_OUT: begin
        // The read data register holds until the next read, so a stalled
        // output simply waits here.
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = ST_OK;
          out_data_nxt.element       = rd_data_r;
          out_data_nxt.element_index = 6'(CW'(ptr_r) + CW'(1));
          out_data_nxt.length        = 6'(occ_r);
          out_data_nxt.final_res     = rd_last;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_RD_REQ;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = st_r;
          out_data_nxt.element       = '0;
          out_data_nxt.element_index = '0;
          out_data_nxt.length        = 6'(occ_r);
          out_data_nxt.final_res     = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    ptr_r      <= ptr_nxt;
    tgt_r      <= tgt_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  // List storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

endmodule

@@ hw/rtl/ple_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg for the transfer structs and status codes.
`timescale 1ns / 1ps

module ple_checker
  import ple_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ple_out_t out_data
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset drops any pending result.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only a read-out element can be non-final, and it carries an index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |->
      out_data.status == ST_OK && out_data.element_index != 6'd0)
    else $error("bad non-final result");

  // Status results carry no element.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.element == '0 && out_data.element_index == 6'd0 &&
      out_data.final_res)
    else $error("status result carries element data");

  // While a read-out is under way no new command is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |-> in_stall)
    else $error("command taken during read-out");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
